>>> rtl/core/hpl_pkg.sv
// Shared constants, tables and types for the humidity piecewise linearizer.
package hpl_pkg;

   // Default converter width and the fixed output width.
   localparam int ADC_BITS_DEF = 10;
   localparam int OUT_BITS     = 10;

   // Breakpoint table: nine points for 10 % .. 90 % relative humidity.
   localparam int POINT_COUNT = 9;
   localparam int POINT_BITS  = 10;
   localparam int SEG_COUNT   = POINT_COUNT - 1;
   localparam int SEG_BITS    = $clog2(SEG_COUNT);

   localparam logic [POINT_BITS-1:0] BREAK_COUNT [POINT_COUNT] = '{
      10'd151, 10'd194, 10'd268, 10'd344, 10'd413,
      10'd485, 10'd550, 10'd612, 10'd653
   };

   // Clamp values and the step between two breakpoints, in tenths of a percent.
   localparam logic [OUT_BITS-1:0] BELOW_VALUE = 10'd90;
   localparam logic [OUT_BITS-1:0] ABOVE_VALUE = 10'd910;
   localparam int                  STEP_VALUE  = 100;

   // Interpolation datapath widths. The offset inside a segment is below the
   // widest segment (76), so it fits 7 bits; offset times 100 fits 13 bits.
   localparam int OFFSET_BITS = 7;
   localparam int PROD_BITS   = 13;
   localparam int QUOT_BITS   = 7;

   // Reciprocals of the segment widths: ceil(2^20 / width). With a 13-bit
   // dividend and widths below 128 the shifted product is the exact floor.
   localparam int RECIP_BITS  = 15;
   localparam int RECIP_SHIFT = 20;
   localparam int EST_BITS    = PROD_BITS + RECIP_BITS;

   localparam logic [RECIP_BITS-1:0] SEG_RECIP [SEG_COUNT] = '{
      15'd24386, // width 43
      15'd14170, // width 74
      15'd13798, // width 76
      15'd15197, // width 69
      15'd14564, // width 72
      15'd16132, // width 65
      15'd16913, // width 62
      15'd25576  // width 41
   };

   // Control that travels with each word down the pipeline.
   typedef struct packed {
      logic                valid;
      logic                interp;
      logic [OUT_BITS-1:0] base;
   } hpl_ctl_type;

endpackage

>>> rtl/core/hpl_interp.sv
// Interpolation stages: offset scaling, reciprocal multiply and final add.
module hpl_interp
   import hpl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  hpl_ctl_type            ctl_i,
   input  logic [OFFSET_BITS-1:0] offset_i,
   input  logic [SEG_BITS-1:0]    seg_i,
   output logic                   valid_o,
   output logic [OUT_BITS-1:0]    value_o
);

   hpl_ctl_type            ctl2_ff, ctl2_in;
   hpl_ctl_type            ctl3_ff;
   logic [PROD_BITS-1:0]   prod2_ff, prod2_in;
   logic [SEG_BITS-1:0]    seg2_ff;
   logic [EST_BITS-1:0]    est3_ff, est3_in;
   logic                   valid4_ff;
   logic [OUT_BITS-1:0]    value4_ff, value4_in;
   logic [QUOT_BITS-1:0]   quot;

   function automatic logic [RECIP_BITS-1:0] seg_recip(input logic [SEG_BITS-1:0] seg);
      seg_recip = SEG_RECIP[seg];
   endfunction

   // Stage 2 scales the segment offset by the step of 100.
   always_comb begin
      ctl2_in  = ctl_i;
      prod2_in = PROD_BITS'(offset_i * PROD_BITS'(STEP_VALUE));
   end

   // Stage 3 multiplies by the reciprocal of the segment width.
   assign est3_in = EST_BITS'(prod2_ff * seg_recip(seg2_ff));

   // Stage 4 takes the quotient and adds the segment's base value.
   always_comb begin
      quot      = est3_ff[RECIP_SHIFT +: QUOT_BITS];
      value4_in = ctl3_ff.interp ? (ctl3_ff.base + OUT_BITS'(quot)) : ctl3_ff.base;
   end

   // Control words and valid bits; reset clears them.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff   <= '0;
         ctl3_ff   <= '0;
         valid4_ff <= 1'b0;
      end else begin
         ctl2_ff   <= ctl2_in;
         ctl3_ff   <= ctl2_ff;
         valid4_ff <= ctl3_ff.valid;
      end
   end

   // Payload registers advance every cycle.
   always_ff @(posedge clock) begin
      prod2_ff  <= prod2_in;
      seg2_ff   <= seg_i;
      est3_ff   <= est3_in;
      value4_ff <= value4_in;
   end

   assign valid_o = valid4_ff;
   assign value_o = value4_ff;

endmodule

>>> rtl/core/humidity_piecewise_linearizer_top.sv
// Top level of the humidity piecewise linearizer: segment search and pipeline.
//
//   channel   ports                                   direction
//   request   start, busy, req_adc_count              in (busy out)
//   response  rsp_strobe, rsp_humidity_tenths         out
//
// A word is taken on every cycle that start is high; busy is always low.
// Each word gives one response after passing four registered stages: stage 1
// classifies the count against the breakpoints, stage 2 scales the offset,
// stage 3 multiplies by the segment reciprocal, stage 4 adds the base.
// Reset clears the valid bits of all four stages. The receiver cannot
// stall, so the pipeline never holds.
module humidity_piecewise_linearizer_top
   import hpl_pkg::*;
#(
   parameter int ADC_BITS = ADC_BITS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [ADC_BITS-1:0] req_adc_count,
   output logic                rsp_strobe,
   output logic [OUT_BITS-1:0] rsp_humidity_tenths
);

   hpl_ctl_type            ctl1_ff, ctl1_in;
   logic [OFFSET_BITS-1:0] offset1_ff, offset1_in;
   logic [SEG_BITS-1:0]    seg1_ff, seg1_in;
   logic [ADC_BITS-1:0]    bp_ext [POINT_COUNT];

   // The pipeline never stalls.
   assign busy = 1'b0;

   // Breakpoints widened to the converter width.
   always_comb begin
      for (int i = 0; i < POINT_COUNT; i++) begin
         bp_ext[i] = ADC_BITS'(BREAK_COUNT[i]);
      end
   end

   // Stage 1 classifies the count: above range, on a breakpoint, inside a
   // segment, or below range.
   always_comb begin
      ctl1_in.valid  = start & ~busy;
      ctl1_in.interp = 1'b0;
      ctl1_in.base   = BELOW_VALUE;
      offset1_in     = '0;
      seg1_in        = '0;
      for (int i = 1; i < POINT_COUNT; i++) begin
         if ((req_adc_count > bp_ext[i-1]) && (req_adc_count < bp_ext[i])) begin
            ctl1_in.interp = 1'b1;
            ctl1_in.base   = OUT_BITS'(i * STEP_VALUE);
            offset1_in     = OFFSET_BITS'(req_adc_count - bp_ext[i-1]);
            seg1_in        = SEG_BITS'(i - 1);
         end
      end
      for (int i = 0; i < POINT_COUNT; i++) begin
         if (req_adc_count == bp_ext[i]) begin
            ctl1_in.base = OUT_BITS'((i + 1) * STEP_VALUE);
         end
      end
      if (req_adc_count > bp_ext[POINT_COUNT-1]) begin
         ctl1_in.interp = 1'b0;
         ctl1_in.base   = ABOVE_VALUE;
      end
   end

   // Stage 1 control word; reset clears its valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
      end else begin
         ctl1_ff <= ctl1_in;
      end
   end

   // Stage 1 payload.
   always_ff @(posedge clock) begin
      offset1_ff <= offset1_in;
      seg1_ff    <= seg1_in;
   end

   hpl_interp u_interp (
      .clock    (clock),
      .reset    (reset),
      .ctl_i    (ctl1_ff),
      .offset_i (offset1_ff),
      .seg_i    (seg1_ff),
      .valid_o  (rsp_strobe),
      .value_o  (rsp_humidity_tenths)
   );

endmodule

>>> rtl/core/hpl_checker.sv
// Port-level checks for the humidity piecewise linearizer, bound to the top.
module hpl_checker
   import hpl_pkg::*;
#(
   parameter int ADC_BITS = ADC_BITS_DEF
)
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [ADC_BITS-1:0] req_adc_count,
   input logic                rsp_strobe,
   input logic [OUT_BITS-1:0] rsp_humidity_tenths
);

   // Every accepted word gives a response.
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("accepted word gave no response");

   // No response appears without an accepted word behind it.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 4))
      else $error("response without a request");

   // Every response lies within the clamp range.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_humidity_tenths >= BELOW_VALUE) &&
                     (rsp_humidity_tenths <= ABOVE_VALUE))
      else $error("response outside range");

   // A count above the last breakpoint clamps high.
   a_above: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_adc_count > ADC_BITS'(BREAK_COUNT[POINT_COUNT-1])))
      |-> ##4 (rsp_humidity_tenths == ABOVE_VALUE))
      else $error("above-range count not clamped");

endmodule

bind humidity_piecewise_linearizer_top hpl_checker #(.ADC_BITS(ADC_BITS)) u_hpl_checker (.*);
